### rtl/sobel_gradient_magnitude_defines.svh
// ----------------------------------------------------------------------------
// sobel gradient magnitude assertion macros
// shared property forms for the checker attached to the top level
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_DEFINES_SVH

// same-cycle implication, off while reset is low
`define SGM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is low
`define SGM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also holds across reset
`define SGM_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// types, constants and the square root step shared by the sobel blocks
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

    // configuration port
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
    localparam int DIM_RESET = 512;
    localparam int DIM_MIN   = 3;

    // input command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // datapath widths
    localparam int PIX_W   = 8;
    localparam int COUNT_W = 21;
    localparam int GRAD_W  = 10;
    localparam int SQ_W    = 2 * GRAD_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int ROOT_W  = SUM_W + 1;
    localparam int MAG_W   = 11;
    localparam logic [MAG_W-1:0] MAG_MAX = 11'd1443;

    // queues
    localparam int MQ_DEPTH = 4;
    localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
    localparam int OQ_DEPTH = 16;
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] pixel;
    } t_in;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             row_end;
        logic             frame_end;
    } t_out;

    // marks that ride along with a result
    typedef struct packed {
        logic row_end;
        logic frame_end;
    } t_mark;

    // work token from the front to the back
    typedef struct packed {
        logic             shift;
        logic             res;
        logic             interior;
        t_mark            mark;
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
        logic [PIX_W-1:0] pixel;
    } t_tok;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    // one digit of the restoring integer square root, test bit 4**i
    function automatic t_sqrt sqrt_step(t_sqrt s, int unsigned i);
        logic [ROOT_W-1:0] bitv;
        logic [ROOT_W-1:0] trial;
        t_sqrt             r;
        bitv  = ROOT_W'(1) << (2 * i);
        trial = s.root + bitv;
        if (s.rem >= trial) begin
            r.rem  = s.rem - trial;
            r.root = (s.root >> 1) + bitv;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/sgm_fifo.sv
// ----------------------------------------------------------------------------
// sgm_fifo
// small register queue; the writer keeps track of free space by count
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic      [WIDTH-1:0]           o_data,
    output logic                            o_empty,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CNTW-1:0]  r_cnt;
    logic             pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, pop_ok})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/sgm_front.sv
// ----------------------------------------------------------------------------
// sgm_front
// accepts beats, tracks raster position, runs the two line stores and
// emits one work token per beat that shifts the window or makes a result
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    input  wire sgm_pkg::t_in                    i_data,
    input  wire logic                            i_cfg_wr,
    input  wire logic [sgm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sgm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                 o_tok_push,
    output sgm_pkg::t_tok                        o_tok,
    output logic                                 o_busy
);

    localparam int DW = sgm_pkg::CFG_DATA_W;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int NW = sgm_pkg::COUNT_W;
    localparam int PW = sgm_pkg::PIX_W;
    localparam int W_RST = (sgm_pkg::DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : sgm_pkg::DIM_RESET;
    localparam int H_RST = (sgm_pkg::DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                             : sgm_pkg::DIM_RESET;
    localparam logic [NW-1:0] COUNT_MAX = '1;

    // clamp a written dimension into its legal range
    function automatic logic [DW-1:0] clamp_dim(logic [DW-1:0] x, int unsigned maxv);
        logic [DW-1:0] r;
        if (32'(x) < sgm_pkg::DIM_MIN) begin
            r = DW'(sgm_pkg::DIM_MIN);
        end else if (32'(x) > maxv) begin
            r = DW'(maxv);
        end else begin
            r = x;
        end
        return r;
    endfunction

    logic [DW-1:0]   r_width;
    logic [DW-1:0]   r_height;
    logic [CW-1:0]   r_col;
    logic [CW-1:0]   n_col;
    logic [NW-1:0]   r_count;
    logic [NW-1:0]   n_count;
    logic [CW-1:0]   r_ocol;
    logic [CW-1:0]   n_ocol;
    logic [RW-1:0]   r_orow;
    logic [RW-1:0]   n_orow;

    // line stores, upper row in the high byte, middle row in the low byte
    logic [2*PW-1:0] r_mem [MAX_WIDTH];
    logic [2*PW-1:0] r_rd;

    logic            r_a_valid;
    logic            r_a_shift;
    logic [CW-1:0]   r_a_col;
    sgm_pkg::t_tok   r_a_tok;

    logic [2*DW-1:0] area;
    logic            pixel_phase;
    logic            take;
    logic            res;
    logic [CW-1:0]   col_c;
    logic            col_last;
    logic            last_col;
    logic            last_row;
    logic            interior;

    // classify the beat at the head of the input
    always_comb begin
        area        = r_width * r_height;
        pixel_phase = 32'(r_count) < 32'(area);
        take        = i_push && !((i_data.command == sgm_pkg::CMD_DRAIN) && pixel_phase);
        res         = 32'(r_count) >= 32'(r_width) + 32'd1;
        col_c       = (32'(r_col) >= 32'(r_width)) ? '0 : r_col;
        col_last    = 32'(col_c) + 32'd1 >= 32'(r_width);
        last_col    = 32'(r_ocol) + 32'd1 >= 32'(r_width);
        last_row    = 32'(r_orow) + 32'd1 >= 32'(r_height);
        interior    = (r_orow != '0) && !last_row && (r_ocol != '0) && !last_col;
    end

    // raster counters
    always_comb begin
        n_col   = r_col;
        n_count = r_count;
        n_ocol  = r_ocol;
        n_orow  = r_orow;
        if (take) begin
            if (pixel_phase) begin
                n_col = col_last ? '0 : CW'(32'(col_c) + 32'd1);
            end
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
            if (res) begin
                if (last_col && last_row) begin
                    n_col   = '0;
                    n_count = '0;
                    n_ocol  = '0;
                    n_orow  = '0;
                end else if (last_col) begin
                    n_ocol = '0;
                    n_orow = r_orow + 1'b1;
                end else begin
                    n_ocol = r_ocol + 1'b1;
                end
            end
        end
    end

    // configuration and counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= DW'(W_RST);
            r_height  <= DW'(H_RST);
            r_col     <= '0;
            r_count   <= '0;
            r_ocol    <= '0;
            r_orow    <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                case (i_cfg_index)
                    sgm_pkg::CFG_IMAGE_WIDTH:  r_width  <= clamp_dim(i_cfg_data, MAX_WIDTH);
                    sgm_pkg::CFG_IMAGE_HEIGHT: r_height <= clamp_dim(i_cfg_data, MAX_HEIGHT);
                    default: ;
                endcase
            end
            r_col     <= n_col;
            r_count   <= n_count;
            r_ocol    <= n_ocol;
            r_orow    <= n_orow;
            r_a_valid <= take;
        end
    end

    // token payload held for the line store read
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_shift              <= pixel_phase;
            r_a_col                <= col_c;
            r_a_tok.shift          <= pixel_phase;
            r_a_tok.res            <= res;
            r_a_tok.interior       <= interior;
            r_a_tok.mark.row_end   <= last_col;
            r_a_tok.mark.frame_end <= last_col && last_row;
            r_a_tok.upper          <= '0;
            r_a_tok.middle         <= '0;
            r_a_tok.pixel          <= i_data.pixel;
        end
    end

    // line stores: read on accept, move middle up and write the new pixel next cycle
    always_ff @(posedge i_clk) begin
        if (take && pixel_phase) begin
            r_rd <= r_mem[col_c];
        end
        if (r_a_valid && r_a_shift) begin
            r_mem[r_a_col] <= {r_rd[PW-1:0], r_a_tok.pixel};
        end
    end

    // token out with the column read from the stores
    always_comb begin
        o_tok        = r_a_tok;
        o_tok.upper  = r_rd[2*PW-1:PW];
        o_tok.middle = r_rd[PW-1:0];
    end

    assign o_tok_push = r_a_valid;
    assign o_busy     = r_a_valid;

endmodule

`default_nettype wire

### rtl/sgm_back.sv
// ----------------------------------------------------------------------------
// sgm_back
// keeps the 3x3 window, forms the sobel gradients and takes the integer
// square root over a short pipeline; pulls tokens only when the result
// queue has room for everything already in flight
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_tok_valid,
    input  wire sgm_pkg::t_tok                 i_tok,
    output logic                               o_tok_pop,
    input  wire logic [sgm_pkg::OQ_CNT_W-1:0]  i_out_count,
    output logic                               o_res_push,
    output sgm_pkg::t_out                      o_res
);

    localparam int PW = sgm_pkg::PIX_W;
    localparam int GW = sgm_pkg::GRAD_W;
    localparam int QW = sgm_pkg::SQ_W;
    localparam int SW = sgm_pkg::SUM_W;
    localparam int MW = sgm_pkg::MAG_W;
    localparam int RTW = sgm_pkg::ROOT_W;
    localparam int NSTG = 7;

    logic [PW-1:0]  r_win [9];

    logic           r_c_v;
    logic           r_c_int;
    sgm_pkg::t_mark r_c_mark;
    logic           r_d_v;
    sgm_pkg::t_mark r_d_mark;
    logic [GW-1:0]  r_d_ah;
    logic [GW-1:0]  r_d_av;
    logic           r_e_v;
    sgm_pkg::t_mark r_e_mark;
    logic [QW-1:0]  r_e_hh;
    logic [QW-1:0]  r_e_vv;
    logic           r_f_v;
    sgm_pkg::t_mark r_f_mark;
    logic [SW-1:0]  r_f_sq;
    logic           r_s_v    [3];
    sgm_pkg::t_mark r_s_mark [3];
    sgm_pkg::t_sqrt r_s_sq   [3];

    logic [NSTG-1:0] busy;
    logic [GW-1:0]   sum_l;
    logic [GW-1:0]   sum_r;
    logic [GW-1:0]   sum_t;
    logic [GW-1:0]   sum_b;
    logic [GW-1:0]   ah;
    logic [GW-1:0]   av;
    sgm_pkg::t_sqrt  s1;
    sgm_pkg::t_sqrt  s2;
    sgm_pkg::t_sqrt  s3;

    // credit check against the result queue
    assign busy      = {r_c_v, r_d_v, r_e_v, r_f_v, r_s_v[0], r_s_v[1], r_s_v[2]};
    assign o_tok_pop = i_tok_valid &&
                       (32'(i_out_count) + 32'($countones(busy)) + 32'd1 <= sgm_pkg::OQ_DEPTH);

    // window shift, new column from the line stores and the input
    always_ff @(posedge i_clk) begin
        if (o_tok_pop && i_tok.shift) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= i_tok.upper;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= i_tok.middle;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= i_tok.pixel;
        end
    end

    // column and row weighted sums, absolute gradients
    always_comb begin
        sum_l = GW'(r_win[0]) + GW'({r_win[3], 1'b0}) + GW'(r_win[6]);
        sum_r = GW'(r_win[2]) + GW'({r_win[5], 1'b0}) + GW'(r_win[8]);
        sum_t = GW'(r_win[0]) + GW'({r_win[1], 1'b0}) + GW'(r_win[2]);
        sum_b = GW'(r_win[6]) + GW'({r_win[7], 1'b0}) + GW'(r_win[8]);
        ah    = (sum_l >= sum_r) ? sum_l - sum_r : sum_r - sum_l;
        av    = (sum_t >= sum_b) ? sum_t - sum_b : sum_b - sum_t;
    end

    // square root digits, four, four and three per stage
    always_comb begin
        s1.rem  = RTW'(r_f_sq);
        s1.root = '0;
        for (int k = 0; k < 4; k++) begin
            s1 = sgm_pkg::sqrt_step(s1, 10 - k);
        end
        s2 = r_s_sq[0];
        for (int k = 0; k < 4; k++) begin
            s2 = sgm_pkg::sqrt_step(s2, 6 - k);
        end
        s3 = r_s_sq[1];
        for (int k = 0; k < 3; k++) begin
            s3 = sgm_pkg::sqrt_step(s3, 2 - k);
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v    <= 1'b0;
            r_d_v    <= 1'b0;
            r_e_v    <= 1'b0;
            r_f_v    <= 1'b0;
            r_s_v[0] <= 1'b0;
            r_s_v[1] <= 1'b0;
            r_s_v[2] <= 1'b0;
        end else begin
            r_c_v    <= o_tok_pop && i_tok.res;
            r_d_v    <= r_c_v;
            r_e_v    <= r_d_v;
            r_f_v    <= r_e_v;
            r_s_v[0] <= r_f_v;
            r_s_v[1] <= r_s_v[0];
            r_s_v[2] <= r_s_v[1];
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        r_c_int     <= i_tok.interior;
        r_c_mark    <= i_tok.mark;
        r_d_ah      <= r_c_int ? ah : '0;
        r_d_av      <= r_c_int ? av : '0;
        r_d_mark    <= r_c_mark;
        r_e_hh      <= r_d_ah * r_d_ah;
        r_e_vv      <= r_d_av * r_d_av;
        r_e_mark    <= r_d_mark;
        r_f_sq      <= SW'(r_e_hh) + SW'(r_e_vv);
        r_f_mark    <= r_e_mark;
        r_s_sq[0]   <= s1;
        r_s_mark[0] <= r_f_mark;
        r_s_sq[1]   <= s2;
        r_s_mark[1] <= r_s_mark[0];
        r_s_sq[2]   <= s3;
        r_s_mark[2] <= r_s_mark[1];
    end

    // result beat
    assign o_res_push      = r_s_v[2];
    assign o_res.magnitude = r_s_sq[2].root[MW-1:0];
    assign o_res.row_end   = r_s_mark[2].row_end;
    assign o_res.frame_end = r_s_mark[2].frame_end;

endmodule

`default_nettype wire

### rtl/sobel_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// Streaming 3x3 sobel gradient magnitude over 8-bit grey raster pixels.
// Input is a queue: write a beat with push while full is low. A beat is a
// pixel (command pixel) or, after the last pixel of a frame, a drain beat;
// width+1 drain beats flush the frame. A drain beat that arrives early is
// dropped. Results are a queue: the oldest result is on o_data while empty
// is low and leaves with pop. Result n belongs to the beat width+1 places
// later, marked with row_end and frame_end; border positions give 0.
// One beat per cycle is taken and one result per cycle is given in steady
// state while the receiver pops, set by the single line store port pair
// (one read, one write per cycle). Width and height are written on the cfg
// port (always ready) while idle, a user rule the block does not enforce.
// Reset (synchronous) empties both queues and restarts the raster at the
// frame origin with 512x512; line stores are not cleared. When the receiver
// stops popping the 16-entry result queue fills and full rises shortly after.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire sgm_pkg::t_in                    i_data,
    output logic                                 empty,
    input  wire logic                            pop,
    output sgm_pkg::t_out                        o_data,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [sgm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sgm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int TOK_W = $bits(sgm_pkg::t_tok);
    localparam int OUT_W = $bits(sgm_pkg::t_out);

    logic                         in_accept;
    logic                         front_busy;
    logic                         tok_push;
    sgm_pkg::t_tok                tok_in;
    logic [TOK_W-1:0]             tok_q;
    logic                         tok_empty;
    logic                         tok_pop;
    logic [sgm_pkg::MQ_CNT_W-1:0] tok_count;
    logic                         res_push;
    sgm_pkg::t_out                res_in;
    logic [OUT_W-1:0]             res_q;
    logic [sgm_pkg::OQ_CNT_W-1:0] res_count;

    // input side holds off while the token queue could overflow
    assign full        = (32'(tok_count) + 32'(front_busy)) >= sgm_pkg::MQ_DEPTH;
    assign in_accept   = push && !full;
    assign o_cfg_ready = 1'b1;

    // front: position tracking and line stores
    sgm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_accept),
        .i_data      (i_data),
        .i_cfg_wr    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_tok_push  (tok_push),
        .o_tok       (tok_in),
        .o_busy      (front_busy)
    );

    // token queue between front and back
    sgm_fifo #(
        .WIDTH (TOK_W),
        .DEPTH (sgm_pkg::MQ_DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (tok_push),
        .i_data  (tok_in),
        .i_pop   (tok_pop),
        .o_data  (tok_q),
        .o_empty (tok_empty),
        .o_count (tok_count)
    );

    // back: window, gradients and square root
    sgm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (!tok_empty),
        .i_tok       (sgm_pkg::t_tok'(tok_q)),
        .o_tok_pop   (tok_pop),
        .i_out_count (res_count),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue toward the receiver
    sgm_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (sgm_pkg::OQ_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty),
        .o_count (res_count)
    );

    assign o_data = sgm_pkg::t_out'(res_q);

endmodule

`default_nettype wire

### rtl/sgm_checker.sv
// ----------------------------------------------------------------------------
// sgm_checker
// port-level checks on the sobel block: the result side, and full after reset
// ----------------------------------------------------------------------------
`include "sobel_gradient_magnitude_defines.svh"
`default_nettype none

module sgm_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          full,
    input wire logic          empty,
    input wire logic          pop,
    input wire sgm_pkg::t_out o_data
);

    // reset leaves no result waiting and the input open
    `SGM_ASSERT_RST(a_reset_clear, i_clk, !i_rst_n, empty && !full, "queues not clear after reset")

    // the frame's last result also closes its row
    `SGM_ASSERT_IMP(a_frame_row_end, i_clk, i_rst_n, !empty && o_data.frame_end, o_data.row_end, "frame_end without row_end")

    // magnitude never exceeds the largest sobel value
    `SGM_ASSERT_IMP(a_mag_range, i_clk, i_rst_n, !empty, o_data.magnitude <= sgm_pkg::MAG_MAX, "magnitude out of range")

    // a waiting result stays put until popped
    `SGM_ASSERT_NXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_data), "waiting result changed")

endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_data  (o_data)
);

`default_nettype wire
